@@ rtl/nsr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package nsr_pkg;

    // name checking window in bytes, at most the 8 bytes of the name field
    localparam int NAME_BYTES = 8;

    localparam logic [4:0] COUNT_MAX = 5'h1f;

    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7a;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_UNDER   = 8'h5f;
    localparam logic [7:0] CH_DASH    = 8'h2d;

    typedef enum logic [2:0] {
        CMD_REGISTER   = 3'd0,
        CMD_LOOKUP     = 3'd1,
        CMD_UNREGISTER = 3'd2,
        CMD_DROP_OWNER = 3'd3,
        CMD_READ_SLOT  = 3'd4,
        CMD_COUNT      = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_READY = 3'd1,
        ST_INVALID   = 3'd2,
        ST_EXISTS    = 3'd3,
        ST_NO_ROOM   = 3'd4,
        ST_NOT_FOUND = 3'd5,
        ST_DENIED    = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_READ,
        S_DRAIN,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [31:0] pid;
        logic [31:0] pgen;
        logic        system_flag;
        logic [31:0] generation;
        logic [63:0] name;
    } entry_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan_clr;
        logic rd_en;
        logic rd_slot;
        logic finish;
    } ctl_t;

    // datapath to controller
    typedef struct packed {
        logic early;
        logic read_only;
        logic scan_last;
    } sts_t;

endpackage

`default_nettype wire

@@ rtl/named_service_registry_table.sv @@
// scanning commands go through decode, a read of every slot, drain and finish
// read slot reads only its slot, decode rejects skip the ram; one slot read per cycle
// commands do not overlap, start is taken only in idle; the slot ram has one read port
// busy drops in the cycle the done strobe shows, so the next start can land on that edge
// the receiver cannot stall: each result is valid for exactly the one done cycle
// reset: async active low, empties all slots and sets the stamp counter to one
`timescale 1ns / 1ps
`default_nettype none

module named_service_registry_table #(
    parameter int CAPACITY = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  cmd,
    input  wire logic [63:0] svc_name,
    input  wire logic [31:0] req_pid,
    input  wire logic [31:0] req_pgen,
    input  wire logic        owner_active,
    input  wire logic        system_flag,
    input  wire logic [7:0]  slot_index,
    output logic             done,
    output logic [2:0]       status,
    output logic [3:0]       hit_slot,
    output logic [31:0]      entry_pid,
    output logic [31:0]      entry_pgen,
    output logic             entry_system_flag,
    output logic [31:0]      entry_stamp,
    output logic [63:0]      entry_name,
    output logic [4:0]       live_count
);

    nsr_pkg::ctl_t ctl;
    nsr_pkg::sts_t sts;

    nsr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy)
    );

    nsr_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .ctl               (ctl),
        .sts               (sts),
        .cmd               (cmd),
        .svc_name          (svc_name),
        .req_pid           (req_pid),
        .req_pgen          (req_pgen),
        .owner_active      (owner_active),
        .system_flag       (system_flag),
        .slot_index        (slot_index),
        .done              (done),
        .status            (status),
        .hit_slot          (hit_slot),
        .entry_pid         (entry_pid),
        .entry_pgen        (entry_pgen),
        .entry_system_flag (entry_system_flag),
        .entry_stamp       (entry_stamp),
        .entry_name        (entry_name),
        .live_count        (live_count)
    );

endmodule

`default_nettype wire

@@ rtl/nsr_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module nsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/nsr_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module nsr_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire nsr_pkg::sts_t sts,
    output nsr_pkg::ctl_t      ctl,
    output logic               busy
);

    nsr_pkg::state_t state_reg;
    nsr_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nsr_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            nsr_pkg::S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = nsr_pkg::S_DECODE;
                end
            end
            nsr_pkg::S_DECODE:
            begin
                ctl.scan_clr = 1'b1;
                priority if (sts.early)
                begin
                    state_next = nsr_pkg::S_FINISH;
                end
                else if (sts.read_only)
                begin
                    state_next = nsr_pkg::S_READ;
                end
                else
                begin
                    state_next = nsr_pkg::S_SCAN;
                end
            end
            nsr_pkg::S_SCAN:
            begin
                ctl.rd_en = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = nsr_pkg::S_DRAIN;
                end
            end
            nsr_pkg::S_READ:
            begin
                ctl.rd_en   = 1'b1;
                ctl.rd_slot = 1'b1;
                state_next  = nsr_pkg::S_DRAIN;
            end
            nsr_pkg::S_DRAIN:
            begin
                // last read beat is compared in this cycle
                state_next = nsr_pkg::S_FINISH;
            end
            nsr_pkg::S_FINISH:
            begin
                ctl.finish = 1'b1;
                state_next = nsr_pkg::S_IDLE;
            end
            default:
            begin
                state_next = nsr_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/nsr_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module nsr_dp #(
    parameter int CAPACITY = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire nsr_pkg::ctl_t ctl,
    output nsr_pkg::sts_t      sts,
    input  wire logic [2:0]    cmd,
    input  wire logic [63:0]   svc_name,
    input  wire logic [31:0]   req_pid,
    input  wire logic [31:0]   req_pgen,
    input  wire logic          owner_active,
    input  wire logic          system_flag,
    input  wire logic [7:0]    slot_index,
    output logic               done,
    output logic [2:0]         status,
    output logic [3:0]         hit_slot,
    output logic [31:0]        entry_pid,
    output logic [31:0]        entry_pgen,
    output logic               entry_system_flag,
    output logic [31:0]        entry_stamp,
    output logic [63:0]        entry_name,
    output logic [4:0]         live_count
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int ENTRY_W = $bits(nsr_pkg::entry_t);

    // captured command
    logic [2:0]  cmd_reg;
    logic [63:0] name_reg;
    logic [31:0] pid_reg;
    logic [31:0] ogen_reg;
    logic        active_reg;
    logic        sysf_reg;
    logic [7:0]  slot_reg;

    logic [CAPACITY-1:0] used_reg;
    logic [31:0]         stamp_reg;
    logic [31:0]         stamp_inc;

    logic [IDX_W-1:0] scan_idx_reg;
    logic             cmp_valid_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic             found_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    nsr_pkg::entry_t  hit_entry_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic [4:0]       cnt_reg;

    logic [IDX_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0] rd_raw;
    nsr_pkg::entry_t    rd_entry;
    logic               cur_used;
    logic               hit_now;
    logic               drop_clr;

    logic        name_ok;
    logic [63:0] name_norm;
    logic        pre_early;
    logic [2:0]  pre_status;

    logic            res_wr;
    logic            res_clr;
    logic [2:0]      res_status;
    logic [IDX_W-1:0] res_idx;
    nsr_pkg::entry_t res_entry;
    nsr_pkg::entry_t new_entry;
    logic [4:0]      res_count;
    logic [IDX_W+3:0] hit_ext;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg    <= cmd;
            name_reg   <= svc_name;
            pid_reg    <= req_pid;
            ogen_reg   <= req_pgen;
            active_reg <= owner_active;
            sysf_reg   <= system_flag;
            slot_reg   <= slot_index;
        end
    end

    // name: first byte a-z, then a-z 0-9 _ - up to a nul inside the window
    always_comb
    begin
        logic term;
        logic bad;
        logic [7:0] b;
        logic lower;
        logic digit;
        term      = 1'b0;
        bad       = 1'b0;
        name_ok   = 1'b0;
        name_norm = '0;
        for (int i = 0; i < nsr_pkg::NAME_BYTES; i++)
        begin
            b     = name_reg[8*i +: 8];
            lower = (b >= nsr_pkg::CH_LOWER_A) && (b <= nsr_pkg::CH_LOWER_Z);
            digit = (b >= nsr_pkg::CH_DIGIT_0) && (b <= nsr_pkg::CH_DIGIT_9);
            if (!term && !bad)
            begin
                if (i == 0 && !lower)
                begin
                    bad = 1'b1;
                end
                else if (b == 8'h00)
                begin
                    term    = 1'b1;
                    name_ok = 1'b1;
                end
                else if (!(lower || digit || b == nsr_pkg::CH_UNDER
                           || b == nsr_pkg::CH_DASH))
                begin
                    bad = 1'b1;
                end
                else
                begin
                    name_norm[8*i +: 8] = b;
                end
            end
        end
    end

    always_comb
    begin
        pre_early  = 1'b0;
        pre_status = nsr_pkg::ST_OK;
        unique case (cmd_reg)
            nsr_pkg::CMD_REGISTER:
            begin
                if (pid_reg == '0 || !active_reg)
                begin
                    pre_early  = 1'b1;
                    pre_status = nsr_pkg::ST_NOT_READY;
                end
                else if (!name_ok)
                begin
                    pre_early  = 1'b1;
                    pre_status = nsr_pkg::ST_INVALID;
                end
            end
            nsr_pkg::CMD_LOOKUP:
            begin
                if (!name_ok)
                begin
                    pre_early  = 1'b1;
                    pre_status = nsr_pkg::ST_INVALID;
                end
            end
            nsr_pkg::CMD_UNREGISTER:
            begin
                if (pid_reg == '0)
                begin
                    pre_early  = 1'b1;
                    pre_status = nsr_pkg::ST_NOT_READY;
                end
                else if (!name_ok)
                begin
                    pre_early  = 1'b1;
                    pre_status = nsr_pkg::ST_INVALID;
                end
            end
            nsr_pkg::CMD_DROP_OWNER:
            begin
                // no owner: nothing to drop, still ok
                pre_early = (pid_reg == '0);
            end
            nsr_pkg::CMD_READ_SLOT:
            begin
                if ({1'b0, slot_reg} >= 9'(CAPACITY))
                begin
                    pre_early  = 1'b1;
                    pre_status = nsr_pkg::ST_INVALID;
                end
            end
            nsr_pkg::CMD_COUNT:
            begin
                pre_early = 1'b0;
            end
            default:
            begin
                pre_early  = 1'b1;
                pre_status = nsr_pkg::ST_INVALID;
            end
        endcase
    end

    assign sts.early     = pre_early;
    assign sts.read_only = (cmd_reg == nsr_pkg::CMD_READ_SLOT);
    assign sts.scan_last = (scan_idx_reg == IDX_W'(CAPACITY - 1));

    assign rd_addr = ctl.rd_slot ? slot_reg[IDX_W-1:0] : scan_idx_reg;

    nsr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (res_wr),
        .waddr (free_idx_reg),
        .wdata (new_entry),
        .re    (ctl.rd_en),
        .raddr (rd_addr),
        .rdata (rd_raw)
    );

    assign rd_entry = rd_raw;
    assign cur_used = used_reg[cmp_idx_reg];
    assign hit_now  = cmp_valid_reg && cur_used
                      && (cmd_reg == nsr_pkg::CMD_READ_SLOT || rd_entry.name == name_norm);
    assign drop_clr = cmp_valid_reg && cur_used && (cmd_reg == nsr_pkg::CMD_DROP_OWNER)
                      && (rd_entry.pid == pid_reg);

    // compare stage, working on the registered read data of the slot ram
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_valid_reg  <= 1'b0;
            scan_idx_reg   <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            cnt_reg        <= '0;
        end
        else
        begin
            cmp_valid_reg <= ctl.rd_en;
            if (ctl.scan_clr)
            begin
                scan_idx_reg   <= '0;
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
                cnt_reg        <= '0;
            end
            else
            begin
                if (ctl.rd_en && !ctl.rd_slot)
                begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                end
                if (hit_now && !found_reg)
                begin
                    found_reg <= 1'b1;
                end
                if (cmp_valid_reg && !cur_used && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                end
                if (cmp_valid_reg && cur_used && cnt_reg != nsr_pkg::COUNT_MAX)
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= rd_addr;
        if (hit_now && !found_reg)
        begin
            hit_idx_reg   <= cmp_idx_reg;
            hit_entry_reg <= rd_entry;
        end
        if (cmp_valid_reg && !cur_used && !free_found_reg)
        begin
            free_idx_reg <= cmp_idx_reg;
        end
    end

    assign new_entry.pid         = pid_reg;
    assign new_entry.pgen        = ogen_reg;
    assign new_entry.system_flag = sysf_reg;
    assign new_entry.generation  = stamp_reg;
    assign new_entry.name        = name_norm;

    always_comb
    begin
        res_wr     = 1'b0;
        res_clr    = 1'b0;
        res_status = pre_status;
        res_idx    = '0;
        res_entry  = '0;
        res_count  = '0;
        if (!pre_early)
        begin
            unique case (cmd_reg)
                nsr_pkg::CMD_REGISTER:
                begin
                    priority if (found_reg)
                    begin
                        res_status = nsr_pkg::ST_EXISTS;
                    end
                    else if (!free_found_reg)
                    begin
                        res_status = nsr_pkg::ST_NO_ROOM;
                    end
                    else
                    begin
                        res_status = nsr_pkg::ST_OK;
                        res_wr     = ctl.finish;
                        res_idx    = free_idx_reg;
                        res_entry  = new_entry;
                    end
                end
                nsr_pkg::CMD_LOOKUP, nsr_pkg::CMD_READ_SLOT:
                begin
                    if (found_reg)
                    begin
                        res_status = nsr_pkg::ST_OK;
                        res_idx    = hit_idx_reg;
                        res_entry  = hit_entry_reg;
                    end
                    else
                    begin
                        res_status = nsr_pkg::ST_NOT_FOUND;
                    end
                end
                nsr_pkg::CMD_UNREGISTER:
                begin
                    priority if (!found_reg)
                    begin
                        res_status = nsr_pkg::ST_NOT_FOUND;
                    end
                    else if (hit_entry_reg.pid != pid_reg
                             || hit_entry_reg.pgen != ogen_reg)
                    begin
                        res_status = nsr_pkg::ST_DENIED;
                        res_idx    = hit_idx_reg;
                    end
                    else
                    begin
                        res_status = nsr_pkg::ST_OK;
                        res_idx    = hit_idx_reg;
                        res_clr    = ctl.finish;
                    end
                end
                nsr_pkg::CMD_DROP_OWNER:
                begin
                    res_status = nsr_pkg::ST_OK;
                end
                nsr_pkg::CMD_COUNT:
                begin
                    res_status = nsr_pkg::ST_OK;
                    res_count  = cnt_reg;
                end
                default:
                begin
                    res_status = nsr_pkg::ST_INVALID;
                end
            endcase
        end
    end

    assign stamp_inc = stamp_reg + 32'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= '0;
            stamp_reg <= 32'd1;
        end
        else
        begin
            if (drop_clr)
            begin
                used_reg[cmp_idx_reg] <= 1'b0;
            end
            if (res_wr)
            begin
                used_reg[free_idx_reg] <= 1'b1;
                // the stamp never takes zero
                stamp_reg <= (stamp_inc == '0) ? 32'd1 : stamp_inc;
            end
            if (res_clr)
            begin
                used_reg[hit_idx_reg] <= 1'b0;
            end
        end
    end

    assign hit_ext = {4'b0000, res_idx};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done <= 1'b0;
        end
        else
        begin
            done <= ctl.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.finish)
        begin
            status            <= res_status;
            hit_slot          <= hit_ext[3:0];
            entry_pid         <= res_entry.pid;
            entry_pgen        <= res_entry.pgen;
            entry_system_flag <= res_entry.system_flag;
            entry_stamp       <= res_entry.generation;
            entry_name        <= res_entry.name;
            live_count        <= res_count;
        end
    end

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    localparam int CAPACITY     = 16;
    localparam int NAME_POOL    = 26;
    localparam int RANDOM_ITEMS = 1260;
    localparam int PRINT_CAP    = 100;

    // command codes the block must reject
    localparam logic [2:0] CMD_BAD_A = 3'd6;
    localparam logic [2:0] CMD_BAD_B = 3'd7;

    typedef struct {
        nsr_pkg::status_t st;
        logic [3:0]  slot;
        logic [31:0] pid;
        logic [31:0] ogen;
        logic        sys;
        logic [31:0] stamp;
        logic [63:0] name;
        logic [4:0]  count;
    } reply_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  cmd;
    logic [63:0] svc_name;
    logic [31:0] req_pid;
    logic [31:0] req_pgen;
    logic        owner_active;
    logic        system_flag;
    logic [7:0]  slot_index;
    logic        done;
    logic [2:0]  status;
    logic [3:0]  hit_slot;
    logic [31:0] entry_pid;
    logic [31:0] entry_pgen;
    logic        entry_system_flag;
    logic [31:0] entry_stamp;
    logic [63:0] entry_name;
    logic [4:0]  live_count;

    // registry image kept alongside the block
    logic        svc_live  [CAPACITY];
    logic [31:0] svc_pid   [CAPACITY];
    logic [31:0] svc_ogen  [CAPACITY];
    logic        svc_sys   [CAPACITY];
    logic [31:0] svc_stamp [CAPACITY];
    logic [63:0] svc_key   [CAPACITY];
    logic [31:0] stamp_next;

    reply_t      pending_replies[$];
    int          mismatches;
    int          burst_left;

    logic [63:0] name_pool      [NAME_POOL];
    logic [31:0] owner_pid_pool [3];
    logic [31:0] owner_gen_pool [3][2];

    named_service_registry_table #(
        .CAPACITY(CAPACITY)
    ) DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .cmd               (cmd),
        .svc_name          (svc_name),
        .req_pid           (req_pid),
        .req_pgen          (req_pgen),
        .owner_active      (owner_active),
        .system_flag       (system_flag),
        .slot_index        (slot_index),
        .done              (done),
        .status            (status),
        .hit_slot          (hit_slot),
        .entry_pid         (entry_pid),
        .entry_pgen        (entry_pgen),
        .entry_system_flag (entry_system_flag),
        .entry_stamp       (entry_stamp),
        .entry_name        (entry_name),
        .live_count        (live_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    function automatic bit name_char_legal(input logic [7:0] b);
        return (b >= nsr_pkg::CH_LOWER_A && b <= nsr_pkg::CH_LOWER_Z)
            || (b >= nsr_pkg::CH_DIGIT_0 && b <= nsr_pkg::CH_DIGIT_9)
            || b == nsr_pkg::CH_UNDER || b == nsr_pkg::CH_DASH;
    endfunction

    // key is the name cut at its first nul, zero padded
    function automatic bit name_valid(input logic [63:0] raw, output logic [63:0] key);
        int i;
        logic [7:0] b;
        key = '0;
        for (i = 0; i < nsr_pkg::NAME_BYTES; i++)
        begin
            b = raw[8*i +: 8];
            if (i == 0 && !(b >= nsr_pkg::CH_LOWER_A && b <= nsr_pkg::CH_LOWER_Z))
                return 1'b0;
            if (b == 8'h00)
            begin
                key = raw & ((64'd1 << (8*i)) - 64'd1);
                return 1'b1;
            end
            if (!name_char_legal(b))
                return 1'b0;
        end
        return 1'b0;
    endfunction

    function automatic int find_key(input logic [63:0] key);
        int i;
        for (i = 0; i < CAPACITY; i++)
            if (svc_live[i] && svc_key[i] == key)
                return i;
        return -1;
    endfunction

    // the stamp survives a clear but is never shown for an empty slot
    function automatic void clear_slot(input int s);
        svc_live[s] = 1'b0;
        svc_pid[s]  = '0;
        svc_ogen[s] = '0;
        svc_sys[s]  = 1'b0;
        svc_key[s]  = '0;
    endfunction

    function automatic void registry_clear();
        int i;
        for (i = 0; i < CAPACITY; i++)
        begin
            clear_slot(i);
            svc_stamp[i] = '0;
        end
        stamp_next = 32'd1;
    endfunction

    function automatic reply_t entry_of(input int s);
        reply_t r;
        r = '{st: nsr_pkg::ST_OK, slot: s[3:0], pid: svc_pid[s], ogen: svc_ogen[s],
              sys: svc_sys[s], stamp: svc_stamp[s], name: svc_key[s], count: '0};
        return r;
    endfunction

    function automatic reply_t registry_reply(input logic [2:0] c, input logic [63:0] raw,
                                              input logic [31:0] pid, input logic [31:0] ogen,
                                              input logic act, input logic sys,
                                              input logic [7:0] idx);
        reply_t r;
        logic [63:0] key;
        int hit;
        int n;
        int i;
        r = '{st: nsr_pkg::ST_OK, slot: '0, pid: '0, ogen: '0, sys: 1'b0, stamp: '0,
              name: '0, count: '0};
        hit = -1;
        n = 0;
        case (c)
            nsr_pkg::CMD_REGISTER:
            begin
                if (pid == 0 || !act)
                    r.st = nsr_pkg::ST_NOT_READY;
                else if (!name_valid(raw, key))
                    r.st = nsr_pkg::ST_INVALID;
                else if (find_key(key) >= 0)
                    r.st = nsr_pkg::ST_EXISTS;
                else
                begin
                    for (i = CAPACITY - 1; i >= 0; i--)
                        if (!svc_live[i])
                            hit = i;
                    if (hit < 0)
                        r.st = nsr_pkg::ST_NO_ROOM;
                    else
                    begin
                        svc_live[hit]  = 1'b1;
                        svc_pid[hit]   = pid;
                        svc_ogen[hit]  = ogen;
                        svc_sys[hit]   = sys;
                        svc_stamp[hit] = stamp_next;
                        svc_key[hit]   = key;
                        stamp_next = stamp_next + 32'd1;
                        if (stamp_next == 0)
                            stamp_next = 32'd1;
                        r = entry_of(hit);
                    end
                end
            end
            nsr_pkg::CMD_LOOKUP:
            begin
                if (!name_valid(raw, key))
                    r.st = nsr_pkg::ST_INVALID;
                else
                begin
                    hit = find_key(key);
                    if (hit < 0)
                        r.st = nsr_pkg::ST_NOT_FOUND;
                    else
                        r = entry_of(hit);
                end
            end
            nsr_pkg::CMD_UNREGISTER:
            begin
                if (pid == 0)
                    r.st = nsr_pkg::ST_NOT_READY;
                else if (!name_valid(raw, key))
                    r.st = nsr_pkg::ST_INVALID;
                else
                begin
                    hit = find_key(key);
                    if (hit < 0)
                        r.st = nsr_pkg::ST_NOT_FOUND;
                    else
                    begin
                        r.slot = hit[3:0];
                        if (svc_pid[hit] != pid || svc_ogen[hit] != ogen)
                            r.st = nsr_pkg::ST_DENIED;
                        else
                            clear_slot(hit);
                    end
                end
            end
            nsr_pkg::CMD_DROP_OWNER:
            begin
                if (pid != 0)
                    for (i = 0; i < CAPACITY; i++)
                        if (svc_live[i] && svc_pid[i] == pid)
                            clear_slot(i);
            end
            nsr_pkg::CMD_READ_SLOT:
            begin
                if (idx >= CAPACITY)
                    r.st = nsr_pkg::ST_INVALID;
                else if (!svc_live[idx])
                    r.st = nsr_pkg::ST_NOT_FOUND;
                else
                    r = entry_of(idx);
            end
            nsr_pkg::CMD_COUNT:
            begin
                for (i = 0; i < CAPACITY; i++)
                    if (svc_live[i])
                        n++;
                r.count = (n > nsr_pkg::COUNT_MAX) ? nsr_pkg::COUNT_MAX : n[4:0];
            end
            default:
                r.st = nsr_pkg::ST_INVALID;
        endcase
        return r;
    endfunction

    function automatic logic [63:0] make_name(input logic [7:0] first, input int len);
        logic [63:0] nm;
        int j;
        int r;
        nm = '0;
        nm[7:0] = first;
        for (j = 1; j < len; j++)
        begin
            r = $urandom_range(0, 37);
            if (r < 26)
                nm[8*j +: 8] = 8'(nsr_pkg::CH_LOWER_A + r);
            else if (r < 36)
                nm[8*j +: 8] = 8'(nsr_pkg::CH_DIGIT_0 + (r - 26));
            else if (r == 36)
                nm[8*j +: 8] = nsr_pkg::CH_UNDER;
            else
                nm[8*j +: 8] = nsr_pkg::CH_DASH;
        end
        return nm;
    endfunction

    // junk past the terminating nul must not change the key
    function automatic logic [63:0] add_tail(input logic [63:0] nm);
        int j;
        int k;
        k = nsr_pkg::NAME_BYTES;
        for (j = 0; j < nsr_pkg::NAME_BYTES; j++)
            if (nm[8*j +: 8] == 8'h00)
            begin
                k = j;
                break;
            end
        if ($urandom_range(0, 1))
            for (j = k + 1; j < 8; j++)
                nm[8*j +: 8] = 8'($urandom_range(0, 255));
        return nm;
    endfunction

    function automatic logic [63:0] bad_name();
        logic [63:0] nm;
        nm = name_pool[$urandom_range(0, NAME_POOL - 1)];
        case ($urandom_range(0, 4))
            0: nm = {$urandom, $urandom};
            1: nm[7:0] = 8'(nsr_pkg::CH_DIGIT_0 + $urandom_range(0, 9));
            2: nm = make_name(8'(nsr_pkg::CH_LOWER_A + $urandom_range(0, 25)), 8);
            3: nm[15:8] = 8'(8'h41 + $urandom_range(0, 25));
            default: nm = '0;
        endcase
        return nm;
    endfunction

    task automatic check_field(input string fld, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            mismatches++;
            if (mismatches <= PRINT_CAP)
                $display("%0t: %s mismatch: expected %h, actual %h", $time, fld, exp_v, act_v);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        reply_t w;
        if (rst_n && done === 1'b1)
        begin
            if (pending_replies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= PRINT_CAP)
                    $display("%0t: result beat with nothing pending: %s %0d",
                             $time, "expected none, actual status", status);
            end
            else
            begin
                w = pending_replies.pop_front();
                check_field("status", 64'(w.st), 64'(status));
                check_field("hit_slot", 64'(w.slot), 64'(hit_slot));
                check_field("entry_pid", 64'(w.pid), 64'(entry_pid));
                check_field("entry_pgen", 64'(w.ogen), 64'(entry_pgen));
                check_field("entry_system_flag", 64'(w.sys), 64'(entry_system_flag));
                check_field("entry_stamp", 64'(w.stamp), 64'(entry_stamp));
                check_field("entry_name", w.name, entry_name);
                check_field("live_count", 64'(w.count), 64'(live_count));
            end
        end
    end

    // bursts of back-to-back commands separated by random gaps
    task automatic send_cmd(input logic [2:0] c, input logic [63:0] nm, input logic [31:0] pid,
                            input logic [31:0] ogen, input logic act, input logic sys,
                            input logic [7:0] idx);
        if (burst_left == 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat ($urandom_range(0, 24)) @(negedge clk);
            burst_left = $urandom_range(1, 40);
        end
        @(negedge clk);
        start        <= 1'b1;
        cmd          <= c;
        svc_name     <= nm;
        req_pid      <= pid;
        req_pgen     <= ogen;
        owner_active <= act;
        system_flag  <= sys;
        slot_index   <= idx;
        do @(posedge clk); while (busy !== 1'b0);
        pending_replies.push_back(registry_reply(c, nm, pid, ogen, act, sys, idx));
        burst_left--;
    endtask

    task automatic test_register_rejects();
        send_cmd(nsr_pkg::CMD_REGISTER, name_pool[0], 32'd0, 32'd5, 1'b1, 1'b0, 8'd0);
        send_cmd(nsr_pkg::CMD_REGISTER, name_pool[0], owner_pid_pool[1], 32'd5, 1'b0, 1'b0,
                 8'd0);
        send_cmd(nsr_pkg::CMD_REGISTER, 64'h0000_0000_0000_6131, owner_pid_pool[1], 32'd5,
                 1'b1, 1'b0, 8'd0);
        send_cmd(nsr_pkg::CMD_REGISTER, 64'd0, owner_pid_pool[1], 32'd5, 1'b1, 1'b0, 8'd0);
        send_cmd(nsr_pkg::CMD_REGISTER, 64'h6867_6665_6463_6261, owner_pid_pool[1], 32'd5,
                 1'b1, 1'b0, 8'd0);
        send_cmd(nsr_pkg::CMD_REGISTER, 64'h0000_0000_0041_6263, owner_pid_pool[1], 32'd5,
                 1'b1, 1'b0, 8'd0);
    endtask

    task automatic test_fill_table();
        int i;
        for (i = 0; i < CAPACITY; i++)
            send_cmd(nsr_pkg::CMD_REGISTER, add_tail(name_pool[i]), owner_pid_pool[i % 3],
                     owner_gen_pool[i % 3][i % 2], 1'b1, i[0], 8'd0);
        send_cmd(nsr_pkg::CMD_REGISTER, name_pool[CAPACITY], owner_pid_pool[1], 32'd7, 1'b1,
                 1'b1, 8'd0);
        send_cmd(nsr_pkg::CMD_REGISTER, add_tail(name_pool[0]), owner_pid_pool[2], 32'd7,
                 1'b1, 1'b1, 8'd0);
        send_cmd(nsr_pkg::CMD_COUNT, 64'd0, 32'd0, 32'd0, 1'b0, 1'b0, 8'd0);
    endtask

    task automatic test_lookup_read();
        send_cmd(nsr_pkg::CMD_LOOKUP, add_tail(name_pool[3]), 32'd0, 32'd0, 1'b0, 1'b0, 8'd0);
        send_cmd(nsr_pkg::CMD_LOOKUP, name_pool[20], 32'd0, 32'd0, 1'b0, 1'b0, 8'd0);
        send_cmd(nsr_pkg::CMD_READ_SLOT, 64'd0, 32'd0, 32'd0, 1'b0, 1'b0, 8'd0);
        send_cmd(nsr_pkg::CMD_READ_SLOT, 64'd0, 32'd0, 32'd0, 1'b0, 1'b0, 8'(CAPACITY - 1));
        send_cmd(nsr_pkg::CMD_READ_SLOT, 64'd0, 32'd0, 32'd0, 1'b0, 1'b0, 8'(CAPACITY));
        send_cmd(nsr_pkg::CMD_READ_SLOT, 64'd0, 32'd0, 32'd0, 1'b0, 1'b0, 8'hff);
    endtask

    task automatic test_unregister();
        logic [31:0] pid;
        logic [31:0] ogen;
        pid  = svc_pid[1];
        ogen = svc_ogen[1];
        send_cmd(nsr_pkg::CMD_UNREGISTER, name_pool[1], pid, ~ogen, 1'b1, 1'b0, 8'd0);
        send_cmd(nsr_pkg::CMD_UNREGISTER, name_pool[1], pid + 32'd1, ogen, 1'b1, 1'b0, 8'd0);
        send_cmd(nsr_pkg::CMD_UNREGISTER, name_pool[1], 32'd0, ogen, 1'b1, 1'b0, 8'd0);
        send_cmd(nsr_pkg::CMD_UNREGISTER, 64'h6867_6665_6463_6261, pid, ogen, 1'b1, 1'b0,
                 8'd0);
        send_cmd(nsr_pkg::CMD_UNREGISTER, add_tail(name_pool[1]), pid, ogen, 1'b0, 1'b0,
                 8'd0);
        send_cmd(nsr_pkg::CMD_UNREGISTER, name_pool[1], pid, ogen, 1'b1, 1'b0, 8'd0);
    endtask

    task automatic test_drop_and_unknown();
        send_cmd(nsr_pkg::CMD_DROP_OWNER, 64'd0, 32'd0, 32'd0, 1'b1, 1'b0, 8'd0);
        send_cmd(nsr_pkg::CMD_DROP_OWNER, 64'd0, owner_pid_pool[0], 32'd0, 1'b1, 1'b0, 8'd0);
        send_cmd(nsr_pkg::CMD_COUNT, 64'd0, 32'd0, 32'd0, 1'b0, 1'b0, 8'd0);
        send_cmd(CMD_BAD_A, name_pool[2], owner_pid_pool[1], 32'd1, 1'b1, 1'b1, 8'd2);
        send_cmd(CMD_BAD_B, name_pool[2], owner_pid_pool[1], 32'd1, 1'b1, 1'b1, 8'd2);
    endtask

    // mostly well-formed traffic on a small name and owner set so that names collide,
    // the table fills up and unregisters find their entries
    task automatic test_random_traffic(input int items);
        int k;
        int sel;
        int o;
        int s;
        int used[$];
        logic [2:0]  c;
        logic [63:0] nm;
        logic [31:0] pid;
        logic [31:0] ogen;
        logic        act;
        logic [7:0]  idx;
        for (k = 0; k < items; k++)
        begin
            sel  = $urandom_range(0, 99);
            o    = $urandom_range(0, 2);
            pid  = owner_pid_pool[o];
            ogen = owner_gen_pool[o][$urandom_range(0, 1)];
            act  = ($urandom_range(0, 19) != 0);
            if ($urandom_range(0, 9) == 0)
                nm = bad_name();
            else
                nm = add_tail(name_pool[$urandom_range(0, NAME_POOL - 1)]);
            if ($urandom_range(0, 19) == 0)
                pid = 32'd0;
            else if ($urandom_range(0, 19) == 0)
                pid = $urandom;
            if (sel < 35)
                c = nsr_pkg::CMD_REGISTER;
            else if (sel < 50)
                c = nsr_pkg::CMD_LOOKUP;
            else if (sel < 70)
            begin
                c = nsr_pkg::CMD_UNREGISTER;
                used = {};
                for (s = 0; s < CAPACITY; s++)
                    if (svc_live[s])
                        used.push_back(s);
                if (used.size() != 0 && $urandom_range(0, 4) < 3)
                begin
                    s    = used[$urandom_range(0, used.size() - 1)];
                    nm   = add_tail(svc_key[s]);
                    pid  = svc_pid[s];
                    ogen = ($urandom_range(0, 4) == 0) ? ~svc_ogen[s] : svc_ogen[s];
                end
            end
            else if (sel < 75)
                c = nsr_pkg::CMD_DROP_OWNER;
            else if (sel < 88)
                c = nsr_pkg::CMD_READ_SLOT;
            else if (sel < 96)
                c = nsr_pkg::CMD_COUNT;
            else
                c = $urandom_range(0, 1) ? CMD_BAD_A : CMD_BAD_B;
            if ($urandom_range(0, 4) == 0)
                idx = 8'($urandom_range(0, 255));
            else
                idx = 8'($urandom_range(0, CAPACITY - 1));
            send_cmd(c, nm, pid, ogen, act, 1'($urandom_range(0, 1)), idx);
        end
    endtask

    initial
    begin : stimulus
        int i;
        rst_n        = 1'b0;
        start        = 1'b0;
        cmd          = '0;
        svc_name     = '0;
        req_pid      = '0;
        req_pgen     = '0;
        owner_active = 1'b0;
        system_flag  = 1'b0;
        slot_index   = '0;
        mismatches   = 0;
        burst_left   = 0;

        // one pool name per first letter keeps the pool free of duplicates
        for (i = 0; i < NAME_POOL; i++)
            name_pool[i] = make_name(8'(nsr_pkg::CH_LOWER_A + i), 1 + (i % 7));
        owner_pid_pool[0]    = 32'hffff_ffff;
        owner_pid_pool[1]    = 32'd1;
        owner_pid_pool[2]    = $urandom_range(2, 32'hffff_fffe);
        owner_gen_pool[0][0] = 32'd0;
        owner_gen_pool[0][1] = 32'hffff_ffff;
        for (i = 1; i < 3; i++)
        begin
            owner_gen_pool[i][0] = $urandom;
            owner_gen_pool[i][1] = $urandom;
        end
        registry_clear();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_register_rejects();
        test_fill_table();
        test_lookup_read();
        test_unregister();
        test_drop_and_unknown();
        test_random_traffic(RANDOM_ITEMS);

        @(negedge clk);
        start <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (4 * CAPACITY) @(posedge clk);
        if (mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
